// File: hw/rtl/otq_pkg.sv
// Shared constants, codes and types of the ordered timer queue.
`timescale 1ns / 1ps
package otq_pkg;
   localparam int SLOTS  = 16;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int SC_W   = $clog2(SLOTS + 1);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int ID_W   = 4;
   localparam int ACT_W  = 3;
   localparam int TIME_W = 48;
   localparam int PER_W  = 32;
   localparam int WIN_W  = 32;
   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60 * 60 * 1000);

   localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_CANCEL  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_REFRESH = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RESET   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_COLLECT = 3'd5;
   localparam logic [ACT_W-1:0] ACT_RSVD0   = 3'd6;
   localparam logic [ACT_W-1:0] ACT_RSVD1   = 3'd7;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [PER_W-1:0]  period;
      logic              repeats;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
endpackage

// File: hw/rtl/otq_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module otq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/ordered_timer_queue.sv
// Ordered timer queue: top level with sequencer and slot memory.
// One request is taken at a time. Every request reads and updates its slot,
// then scans the slot memory once for the earliest armed deadline and then
// delivers its response beats. A collect with any armed slot adds one scan to
// mark the expired slots and one scan per expired slot, plus a last one that
// finds none, to pick them in deadline order. All scans go through the one
// read port of the slot memory, one slot per cycle. There is no clearing pass
// after reset.
`timescale 1ns / 1ps
module ordered_timer_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // timer_id, period, recurring, rebase, now
   input  logic [87:0]                req_tdata,
   // action
   input  logic [otq_pkg::ACT_W-1:0]  req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // ok, is_earliest, has_timer, wait_time, expired_id
   output logic [55:0]                rsp_tdata,
   // expired_valid
   output logic [0:0]                 rsp_tuser,
   output logic                       rsp_tlast,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [otq_pkg::WIN_W-1:0]  csr_data
);
   import otq_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_XSCAN = 3'd3;
   localparam logic [2:0] ST_PSCAN = 3'd4;
   localparam logic [2:0] ST_ESCAN = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0]        st_ff, st_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [PER_W-1:0]  rc_ff, rc_in;
   logic              rec_ff, rec_in, fn_ff, fn_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic              ok_ff, ok_in, roll_ff, roll_in, early_ff, early_in;
   logic              has_ff, has_in;
   logic [TIME_W-1:0] prev_ff, prev_in, wait_ff, wait_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [SLOTS-1:0]  armed_ff, armed_in, xm_ff, xm_in, tk_ff, tk_in;
   logic [SC_W-1:0]   sc_ff, sc_in;
   logic              pv_ff, pv_in;
   logic [SLOT_W-1:0] pi_ff, pi_in, bi_ff, bi_in;
   logic              bf_ff, bf_in, br_ff, br_in;
   logic [TIME_W-1:0] bd_ff, bd_in;
   logic [PER_W-1:0]  bp_ff, bp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, eidx_ff, eidx_in;
   logic [SLOT_W-1:0] list_ff [SLOTS];
   logic [SLOT_W-1:0] list_in [SLOTS];

   logic              we;
   logic [SLOT_W-1:0] waddr, raddr;
   entry_type         wdata, rdata;
   logic [SLOT_W-1:0] slot;
   logic              inrange, hit, issuing, scan_done, cand, better;
   logic [TIME_W-1:0] base, wvec;
   logic [TIME_W-1:0] addend;
   logic              last_beat;

   otq_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(waddr),
      .wr_data(wdata),
      .rd_addr(raddr),
      .rd_data(rdata)
   );

   assign slot      = SLOT_W'(id_ff);
   assign inrange   = 32'(id_ff) < SLOTS;
   assign hit       = inrange && armed_ff[slot];
   assign issuing   = sc_ff != SC_W'(SLOTS);
   assign scan_done = !issuing && !pv_ff;
   assign better    = !bf_ff || (rdata.deadline < bd_ff);
   assign last_beat = (cnt_ff == '0) || (eidx_ff == cnt_ff - CNT_W'(1));

   assign req_tready = st_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = st_ff == ST_EMIT;
   assign rsp_tlast  = last_beat;
   assign rsp_tuser  = cnt_ff != '0;
   assign rsp_tdata  = {1'b0,
                        (cnt_ff == '0) ? ID_W'(0) : ID_W'(list_ff[SLOT_W'(eidx_ff)]),
                        wait_ff, has_ff, early_ff, ok_ff};

   always_comb begin
      unique case (st_ff)
         ST_XSCAN: cand = armed_ff[pi_ff];
         ST_PSCAN: cand = xm_ff[pi_ff] && !tk_ff[pi_ff];
         ST_ESCAN: cand = armed_ff[pi_ff];
         default:  cand = 1'b0;
      endcase
      priority if (act_ff == ACT_ADD) begin
         base   = now_ff;
         addend = TIME_W'(rc_ff);
      end else if (act_ff == ACT_REFRESH) begin
         base   = now_ff;
         addend = TIME_W'(rdata.period);
      end else if (fn_ff) begin
         base   = now_ff;
         addend = TIME_W'(rc_ff);
      end else begin
         base   = rdata.deadline - TIME_W'(rdata.period);
         addend = TIME_W'(rc_ff);
      end
      wvec = base + addend;
   end

   always_comb begin
      st_in    = st_ff;
      act_in   = act_ff;
      id_in    = id_ff;
      rc_in    = rc_ff;
      rec_in   = rec_ff;
      fn_in    = fn_ff;
      now_in   = now_ff;
      ok_in    = ok_ff;
      roll_in  = roll_ff;
      early_in = early_ff;
      has_in   = has_ff;
      prev_in  = prev_ff;
      wait_in  = wait_ff;
      win_in   = win_ff;
      armed_in = armed_ff;
      xm_in    = xm_ff;
      tk_in    = tk_ff;
      sc_in    = sc_ff;
      pv_in    = 1'b0;
      pi_in    = pi_ff;
      bi_in    = bi_ff;
      bf_in    = bf_ff;
      br_in    = br_ff;
      bd_in    = bd_ff;
      bp_in    = bp_ff;
      cnt_in   = cnt_ff;
      eidx_in  = eidx_ff;
      list_in  = list_ff;
      we       = 1'b0;
      waddr    = slot;
      wdata    = '{deadline: wvec, period: rc_ff, repeats: rdata.repeats};
      raddr    = slot;

      if (csr_valid && csr_ready) begin
         win_in = csr_data;
      end

      if (st_ff == ST_XSCAN || st_ff == ST_PSCAN || st_ff == ST_ESCAN) begin
         raddr = sc_ff[SLOT_W-1:0];
         if (issuing) begin
            sc_in = sc_ff + SC_W'(1);
            pv_in = 1'b1;
            pi_in = sc_ff[SLOT_W-1:0];
         end
         if (pv_ff && cand) begin
            if (st_ff == ST_XSCAN) begin
               xm_in[pi_ff] = roll_ff || (rdata.deadline <= now_ff);
            end else if (better) begin
               bf_in = 1'b1;
               bi_in = pi_ff;
               bd_in = rdata.deadline;
               bp_in = rdata.period;
               br_in = rdata.repeats;
            end
         end
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in  = req_tuser;
               id_in   = req_tdata[3:0];
               rc_in   = req_tdata[35:4];
               rec_in  = req_tdata[36];
               fn_in   = req_tdata[37];
               now_in  = req_tdata[85:38];
               cnt_in  = '0;
               eidx_in = '0;
               early_in = 1'b0;
               st_in   = ST_READ;
            end
         end
         ST_READ: begin
            st_in = ST_MOD;
         end
         ST_MOD: begin
            ok_in = 1'b0;
            sc_in = '0;
            bf_in = 1'b0;
            st_in = ST_ESCAN;
            unique case (act_ff)
               ACT_ADD: begin
                  if (inrange) begin
                     we    = 1'b1;
                     wdata = '{deadline: wvec, period: rc_ff, repeats: rec_ff};
                     armed_in[slot] = 1'b1;
                     ok_in = 1'b1;
                  end
               end
               ACT_CANCEL: begin
                  if (hit) begin
                     armed_in[slot] = 1'b0;
                     ok_in = 1'b1;
                  end
               end
               ACT_REFRESH: begin
                  if (hit) begin
                     we    = 1'b1;
                     wdata = '{deadline: wvec, period: rdata.period,
                               repeats: rdata.repeats};
                     ok_in = 1'b1;
                  end
               end
               ACT_RESET: begin
                  if (hit) begin
                     ok_in = 1'b1;
                     we    = !(rc_ff == rdata.period && !fn_ff);
                  end
               end
               ACT_QUERY: begin
                  ok_in = 1'b1;
               end
               ACT_COLLECT: begin
                  ok_in = 1'b1;
                  if (armed_ff != '0) begin
                     roll_in = (prev_ff >= TIME_W'(win_ff)) &&
                               (now_ff < prev_ff - TIME_W'(win_ff));
                     prev_in = now_ff;
                     xm_in   = '0;
                     tk_in   = '0;
                     st_in   = ST_XSCAN;
                  end
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end
         ST_XSCAN: begin
            if (scan_done) begin
               sc_in = '0;
               bf_in = 1'b0;
               st_in = ST_PSCAN;
            end
         end
         ST_PSCAN: begin
            if (scan_done) begin
               sc_in = '0;
               bf_in = 1'b0;
               if (bf_ff) begin
                  tk_in[bi_ff] = 1'b1;
                  list_in[cnt_ff[SLOT_W-1:0]] = bi_ff;
                  cnt_in = cnt_ff + CNT_W'(1);
                  waddr  = bi_ff;
                  wdata  = '{deadline: now_ff + TIME_W'(bp_ff), period: bp_ff,
                             repeats: br_ff};
                  if (br_ff) begin
                     we = 1'b1;
                  end else begin
                     armed_in[bi_ff] = 1'b0;
                  end
               end else begin
                  st_in = ST_ESCAN;
               end
            end
         end
         ST_ESCAN: begin
            if (scan_done) begin
               has_in   = bf_ff;
               early_in = (act_ff == ACT_ADD) && ok_ff && bf_ff && (bi_ff == slot);
               if (!bf_ff) begin
                  wait_in = '1;
               end else if (now_ff >= bd_ff) begin
                  wait_in = '0;
               end else begin
                  wait_in = bd_ff - now_ff;
               end
               st_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (last_beat) begin
                  st_in = ST_IDLE;
               end else begin
                  eidx_in = eidx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         armed_ff <= '0;
         prev_ff  <= '0;
         win_ff   <= WINDOW_RESET;
         pv_ff    <= 1'b0;
         cnt_ff   <= '0;
         eidx_ff  <= '0;
      end else begin
         st_ff    <= st_in;
         armed_ff <= armed_in;
         prev_ff  <= prev_in;
         win_ff   <= win_in;
         pv_ff    <= pv_in;
         cnt_ff   <= cnt_in;
         eidx_ff  <= eidx_in;
      end
      act_ff   <= act_in;
      id_ff    <= id_in;
      rc_ff    <= rc_in;
      rec_ff   <= rec_in;
      fn_ff    <= fn_in;
      now_ff   <= now_in;
      ok_ff    <= ok_in;
      roll_ff  <= roll_in;
      early_ff <= early_in;
      has_ff   <= has_in;
      wait_ff  <= wait_in;
      xm_ff    <= xm_in;
      tk_ff    <= tk_in;
      sc_ff    <= sc_in;
      pi_ff    <= pi_in;
      bi_ff    <= bi_in;
      bf_ff    <= bf_in;
      br_ff    <= br_in;
      bd_ff    <= bd_in;
      bp_ff    <= bp_in;
      list_ff  <= list_in;
   end
endmodule

// File: hw/rtl/otq_checker.sv
// Port-level checks of the ordered timer queue, bound to the top level.
`timescale 1ns / 1ps
module otq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid)
      else $error("request taken while a response is pending");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("beat without expired slot is not last");

   a_empty_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[50:3] == 48'hFFFF_FFFF_FFFF)
      else $error("no timer armed but wait time is not all ones");
endmodule

bind ordered_timer_queue otq_checker u_otq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);
